[design/ksm_pkg.sv]
package ksm_pkg;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 8'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] PROCESS_NOISE_RESET = 32'd0;
   localparam logic [CSR_DATA_WIDTH-1:0] MEASUREMENT_NOISE_RESET = 32'd65536;

   typedef struct packed {
      logic sub;
      logic zero_b;
   } alu_ctrl_type;

endpackage

[design/ksm_addsub.sv]
module ksm_addsub #(
   parameter int WIDTH = 34
) (
   input  logic [WIDTH-1:0]    op_a,
   input  logic [WIDTH-1:0]    op_b,
   input  ksm_pkg::alu_ctrl_type ctrl,
   output logic [WIDTH-1:0]    result,
   output logic                carry
);
   import ksm_pkg::*;

   logic [WIDTH-1:0] b_gated;
   logic [WIDTH-1:0] b_eff;

   assign b_gated = ctrl.zero_b ? '0 : op_b;
   assign b_eff = ctrl.sub ? ~b_gated : b_gated;
   assign {carry, result} = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, ctrl.sub};

endmodule

[design/scalar_kalman_smoother.sv]
// Scalar Kalman smoother for a heading signal, constant-state model.
// The req channel carries one item per heading sample: a signed fixed-point
// sample and a flag that starts a new sequence. The rsp channel returns one
// item per request with the updated estimate. The csr channel writes the
// process noise (index 0) and measurement noise (index 1) registers; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. A first sample of a sequence goes
// straight to the write state. Any other item goes through the covariance
// update, the gain division (skipped when the gain denominator is zero),
// the innovation (negated in an extra state when the sample lies below
// the estimate) and the correction; one adder is shared by the covariance
// update, a restoring divider for the gain, and two shift-add multipliers,
// each FRAC_BITS + 1 steps long. req_ready is high only while the sequencer
// is idle and rises with rsp_valid, so one item is worked on at a time.
// The result sits in an output register. A stalled receiver holds it there
// while the next item is accepted and computed; the sequencer waits in its
// last state only if a new result is ready before the old one is taken.
// Reset clears the estimate to zero, the covariance to 1.0 and the noise
// registers to 0 and 1.0, and drops any pending result.
module scalar_kalman_smoother #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_first_sample,
   input  logic signed [DATA_WIDTH-1:0]        req_yaw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [DATA_WIDTH-1:0]        rsp_filtered_yaw,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ksm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ksm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ksm_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int F = FRAC_BITS;
   localparam int BASE = (W > CSR_DATA_WIDTH) ? W : CSR_DATA_WIDTH;
   localparam int AW = BASE + 2;
   localparam int CW = (W > F) ? W : F + 1;
   localparam int CNT_W = $clog2(F + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(F);
   localparam logic [AW-1:0] ONE_AW = AW'(1) << F;
   localparam logic [F:0] ONE_GAIN = (F + 1)'(1) << F;
   localparam logic [CW-1:0] ONE_COV = CW'(1) << F;
   localparam logic [CW-1:0] COV_MAX = CW'({W{1'b1}});

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_Q,
      ST_ADD_R,
      ST_DIV,
      ST_DIFF,
      ST_DIFF_NEG,
      ST_MUL_E,
      ST_APPLY,
      ST_INVG,
      ST_MUL_P,
      ST_WRITE
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [W-1:0]               sample_ff;
   logic [W-1:0]               est_ff;
   logic [CW-1:0]              cov_ff;
   logic [AW-1:0]              p_ff;
   logic [AW-1:0]              den_ff;
   logic [AW-1:0]              rem_ff;
   logic [F:0]                 q_ff;
   logic [AW-1:0]              mcand_ff;
   logic [AW-1:0]              acc_ff;
   logic [F:0]                 gsh_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff;
   logic [W-1:0]               rsp_yaw_ff;
   logic [CSR_DATA_WIDTH-1:0]  pn_ff;
   logic [CSR_DATA_WIDTH-1:0]  rn_ff;

   logic [AW-1:0]              alu_a;
   logic [AW-1:0]              alu_b;
   alu_ctrl_type               alu_ctrl;
   logic [AW-1:0]              alu_sum;
   logic                       alu_carry;
   logic [AW-1:0]              sample_ext;
   logic [AW-1:0]              est_ext;
   logic [AW-1:0]              rem_shift;
   logic [AW-1:0]              acc_in;
   logic                       mul_last;

   assign sample_ext = {{(AW - W){sample_ff[W-1]}}, sample_ff};
   assign est_ext = {{(AW - W){est_ff[W-1]}}, est_ff};
   assign rem_shift = (cnt_ff == '0) ? rem_ff : {rem_ff[AW-2:0], 1'b0};
   assign mul_last = (cnt_ff == CNT_LAST);
   assign acc_in = mul_last ? alu_sum : {1'b0, alu_sum[AW-1:1]};

   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_ctrl = '{sub: 1'b0, zero_b: 1'b0};
      case (state_ff)
         ST_ADD_Q: begin
            alu_a = AW'(cov_ff);
            alu_b = AW'(pn_ff);
         end
         ST_ADD_R: begin
            alu_a = p_ff;
            alu_b = AW'(rn_ff);
         end
         ST_DIV: begin
            alu_a = rem_shift;
            alu_b = den_ff;
            alu_ctrl.sub = 1'b1;
         end
         ST_DIFF: begin
            alu_a = sample_ext;
            alu_b = est_ext;
            alu_ctrl.sub = 1'b1;
         end
         ST_DIFF_NEG: begin
            alu_a = est_ext;
            alu_b = sample_ext;
            alu_ctrl.sub = 1'b1;
         end
         ST_MUL_E, ST_MUL_P: begin
            alu_a = acc_ff;
            alu_b = mcand_ff;
            alu_ctrl.zero_b = ~gsh_ff[0];
         end
         ST_APPLY: begin
            alu_a = est_ext;
            alu_b = acc_ff;
            alu_ctrl.sub = neg_ff;
         end
         ST_INVG: begin
            alu_a = ONE_AW;
            alu_b = AW'(q_ff);
            alu_ctrl.sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   ksm_addsub #(
      .WIDTH(AW)
   ) u_addsub (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .ctrl   (alu_ctrl),
      .result (alu_sum),
      .carry  (alu_carry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         est_ff <= '0;
         cov_ff <= ONE_COV;
         rsp_valid_ff <= 1'b0;
         pn_ff <= PROCESS_NOISE_RESET;
         rn_ff <= MEASUREMENT_NOISE_RESET;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_PROCESS_NOISE: pn_ff <= csr_data;
               CSR_MEASUREMENT_NOISE: rn_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_WRITE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sample_ff <= req_yaw_sample;
                  if (req_first_sample) begin
                     est_ff <= req_yaw_sample;
                     cov_ff <= ONE_COV;
                     state_ff <= ST_WRITE;
                  end else begin
                     state_ff <= ST_ADD_Q;
                  end
               end
            end
            ST_ADD_Q: begin
               if (alu_sum[AW-1:W] != '0) begin
                  p_ff <= AW'(COV_MAX);
               end else begin
                  p_ff <= alu_sum;
               end
               state_ff <= ST_ADD_R;
            end
            ST_ADD_R: begin
               den_ff <= alu_sum;
               rem_ff <= p_ff;
               q_ff <= (alu_sum == '0) ? ONE_GAIN : '0;
               cnt_ff <= '0;
               if (alu_sum == '0) begin
                  state_ff <= ST_DIFF;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= alu_carry ? alu_sum : rem_shift;
               q_ff <= {q_ff[F-1:0], alu_carry};
               cnt_ff <= cnt_ff + 1'b1;
               if (mul_last) begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               neg_ff <= alu_sum[AW-1];
               mcand_ff <= alu_sum;
               acc_ff <= '0;
               gsh_ff <= q_ff;
               cnt_ff <= '0;
               state_ff <= alu_sum[AW-1] ? ST_DIFF_NEG : ST_MUL_E;
            end
            ST_DIFF_NEG: begin
               mcand_ff <= alu_sum;
               state_ff <= ST_MUL_E;
            end
            ST_MUL_E, ST_MUL_P: begin
               acc_ff <= acc_in;
               gsh_ff <= {1'b0, gsh_ff[F:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (mul_last) begin
                  if (state_ff == ST_MUL_E) begin
                     state_ff <= ST_APPLY;
                  end else begin
                     cov_ff <= acc_in[CW-1:0];
                     state_ff <= ST_WRITE;
                  end
               end
            end
            ST_APPLY: begin
               est_ff <= alu_sum[W-1:0];
               state_ff <= ST_INVG;
            end
            ST_INVG: begin
               gsh_ff <= alu_sum[F:0];
               mcand_ff <= p_ff;
               acc_ff <= '0;
               cnt_ff <= '0;
               state_ff <= ST_MUL_P;
            end
            ST_WRITE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_yaw_ff <= est_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_yaw = rsp_yaw_ff;
   assign csr_ready = 1'b1;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block still ready after taking an item");

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> (q_ff <= ONE_GAIN))
      else $error("gain above 1.0");

   a_corr_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (acc_ff <= mcand_ff))
      else $error("correction larger than the innovation");

   a_cov_not_grown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_P && mul_last) |-> (acc_in <= p_ff))
      else $error("covariance grew in the measurement update");

endmodule
